@@ src/knngf_pkg.sv @@
// Shared types and constants for the k-nearest-neighbor gap filler.
package knngf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAP_W    = 7;
	localparam int MODE_W   = 2;
	localparam int K_W      = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 5;

	localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_KIND    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = 1'd1;

	localparam logic [K_W-1:0] K_RESET = 5'd1;

	typedef struct packed {
		logic [MODE_W-1:0]          mode;
		logic signed [SAMPLE_W-1:0] sample_value;
		logic [GAP_W-1:0]           gap_length;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filled_sample;
		logic                       no_neighbours;
		logic                       last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_MED,
		ST_DIVS,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_left;
		logic load_right;
		logic start_fill;
		logic clear_ctx;
		logic pos_init;
		logic next_pos;
		logic pick;
		logic med_a;
		logic div_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic pick_go;
		logic n_zero;
		logic median;
		logic div_idle;
		logic pos_last;
		logic len_zero;
	} status_t;

endpackage

@@ src/knngf_ctrl.sv @@
// Sequencer for context loads, neighbor picking, division and result beats.
module knngf_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [knngf_pkg::MODE_W-1:0] in_mode,
	output logic                         in_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  knngf_pkg::status_t           status,
	output knngf_pkg::cmd_t              cmd
);

	knngf_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic slot_free;
	logic in_acc;

	assign in_ready  = (state_q == knngf_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			knngf_pkg::ST_IDLE: begin
				if (in_acc && in_mode == knngf_pkg::MODE_FILL && !status.len_zero)
					state_d = knngf_pkg::ST_PICK;
			end
			knngf_pkg::ST_PICK: begin
				if (!status.pick_go) begin
					if (status.n_zero)
						state_d = knngf_pkg::ST_EMIT;
					else if (status.median)
						state_d = knngf_pkg::ST_MED;
					else
						state_d = knngf_pkg::ST_DIVS;
				end
			end
			knngf_pkg::ST_MED:  state_d = knngf_pkg::ST_DIVS;
			knngf_pkg::ST_DIVS: state_d = knngf_pkg::ST_DIV;
			knngf_pkg::ST_DIV: begin
				if (status.div_idle)
					state_d = knngf_pkg::ST_EMIT;
			end
			knngf_pkg::ST_EMIT: begin
				if (slot_free)
					state_d = status.pos_last ? knngf_pkg::ST_IDLE : knngf_pkg::ST_PICK;
			end
			default: state_d = knngf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			knngf_pkg::ST_IDLE: begin
				if (in_acc) begin
					cmd.load_left  = (in_mode == knngf_pkg::MODE_LEFT);
					cmd.load_right = (in_mode == knngf_pkg::MODE_RIGHT);
					if (in_mode == knngf_pkg::MODE_FILL) begin
						cmd.start_fill = 1'b1;
						cmd.pos_init   = 1'b1;
						cmd.clear_ctx  = status.len_zero;
					end
				end
			end
			knngf_pkg::ST_PICK: cmd.pick = status.pick_go;
			knngf_pkg::ST_MED:  cmd.med_a = 1'b1;
			knngf_pkg::ST_DIVS: cmd.div_start = 1'b1;
			knngf_pkg::ST_DIV:  ;
			knngf_pkg::ST_EMIT: begin
				if (slot_free) begin
					cmd.emit      = 1'b1;
					cmd.clear_ctx = status.pos_last;
					cmd.next_pos  = !status.pos_last;
					cmd.pos_init  = !status.pos_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= knngf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ src/knngf_dp.sv @@
// Context windows, neighbor picker, sorted pick buffer, serial divider, result register.
module knngf_dp #(
	parameter int MAX_K   = 16,
	parameter int MAX_GAP = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  knngf_pkg::in_item_t             in_data,
	input  logic                            cfg_we,
	input  logic [knngf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [knngf_pkg::CFG_W-1:0]     cfg_data,
	input  knngf_pkg::cmd_t                 cmd,
	output knngf_pkg::status_t              status,
	output knngf_pkg::out_item_t            out_data
);

	localparam int SW   = knngf_pkg::SAMPLE_W;
	localparam int GW   = knngf_pkg::GAP_W;
	localparam int KW   = knngf_pkg::K_W;
	localparam int CW   = $clog2(MAX_K + 1);
	localparam int IW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int PK   = 2 * MAX_K;
	localparam int NW   = $clog2(PK + 1);
	localparam int BW   = NW - 1;
	localparam int SUMW = SW + NW;
	localparam int DW   = GW + CW + 2;
	localparam int DCW  = $clog2(SUMW + 1);

	logic signed [SW-1:0] left_win_q [MAX_K];
	logic signed [SW-1:0] right_win_q [MAX_K];
	logic [CW-1:0] lc_q, rc_q, lu_q, ru_q;
	logic avg_kind_q;
	logic [KW-1:0] k_q;
	logic [GW-1:0] len_q, pos_q, len_sat;
	logic [KW-1:0] step_q;
	logic [NW-1:0] n_q;
	logic signed [SUMW-1:0] sum_q;
	logic signed [SW-1:0] buf_q [PK];
	logic signed [SW-1:0] med_a_q;

	logic [SUMW-1:0] quo_q;
	logic [NW-1:0] dvs_q, rem_q;
	logic [DCW-1:0] div_cnt_q;
	logic neg_q;

	logic left_ok, right_ok, take_right, pick_go;
	logic [DW-1:0] dist_r, dist_l;
	logic signed [SW-1:0] pick_val;
	logic [PK-1:0] gt;
	logic [BW-1:0] mid_idx, mid_lo_idx;
	logic signed [SUMW-1:0] dvd;
	logic [NW:0] trial;
	logic [SUMW-1:0] mag;
	logic signed [SUMW-1:0] quo_signed;

	assign len_sat = (in_data.gap_length > GW'(MAX_GAP)) ? GW'(MAX_GAP) : in_data.gap_length;

	assign left_ok  = lu_q < lc_q;
	assign right_ok = ru_q < rc_q;
	assign dist_r   = DW'(len_q) - DW'(pos_q) + DW'(ru_q);
	assign dist_l   = DW'(pos_q) + DW'(1) + DW'(lu_q);
	assign take_right = !left_ok || (right_ok && dist_r < dist_l);
	assign pick_go  = (step_q < k_q) && (left_ok || right_ok);
	assign pick_val = take_right ? right_win_q[ru_q[IW-1:0]] : left_win_q[lu_q[IW-1:0]];

	// slots at or past the fill point, or holding a larger value, move up
	always_comb begin
		for (int i = 0; i < PK; i++)
			gt[i] = (NW'(i) >= n_q) || (buf_q[i] > pick_val);
	end

	assign mid_idx    = n_q[NW-1:1];
	assign mid_lo_idx = mid_idx - BW'(1);

	always_comb begin
		if (avg_kind_q) begin
			if (n_q[0])
				dvd = SUMW'(med_a_q);
			else
				dvd = SUMW'(med_a_q) + SUMW'(buf_q[mid_lo_idx]);
		end else begin
			dvd = sum_q;
		end
	end

	assign mag   = dvd[SUMW-1] ? SUMW'(-dvd) : SUMW'(dvd);
	assign trial = {rem_q, quo_q[SUMW-1]};
	assign quo_signed = neg_q ? -$signed(quo_q) : $signed(quo_q);

	assign status.pick_go  = pick_go;
	assign status.n_zero   = (n_q == '0);
	assign status.median   = avg_kind_q;
	assign status.div_idle = (div_cnt_q == '0);
	assign status.pos_last = (pos_q + GW'(1) == len_q);
	assign status.len_zero = (in_data.gap_length == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_kind_q <= 1'b0;
			k_q        <= knngf_pkg::K_RESET;
			lc_q       <= '0;
			rc_q       <= '0;
			div_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					knngf_pkg::REG_AVERAGE_KIND:    avg_kind_q <= cfg_data[0];
					knngf_pkg::REG_NEIGHBOUR_COUNT: k_q <= cfg_data[KW-1:0];
					default: ;
				endcase
			end
			if (cmd.clear_ctx) begin
				lc_q <= '0;
				rc_q <= '0;
			end else begin
				if (cmd.load_left && lc_q < CW'(MAX_K))
					lc_q <= lc_q + CW'(1);
				if (cmd.load_right && rc_q < CW'(MAX_K))
					rc_q <= rc_q + CW'(1);
			end
			// the median at most halves, so it skips the serial steps
			if (cmd.div_start)
				div_cnt_q <= avg_kind_q ? '0 : DCW'(SUMW);
			else if (div_cnt_q != '0)
				div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_left) begin
			for (int i = MAX_K - 1; i > 0; i--)
				left_win_q[i] <= left_win_q[i-1];
			left_win_q[0] <= in_data.sample_value;
		end
		if (cmd.load_right && rc_q < CW'(MAX_K))
			right_win_q[rc_q[IW-1:0]] <= in_data.sample_value;

		if (cmd.start_fill) begin
			len_q <= len_sat;
			pos_q <= '0;
		end else if (cmd.next_pos) begin
			pos_q <= pos_q + GW'(1);
		end

		if (cmd.pos_init) begin
			lu_q   <= '0;
			ru_q   <= '0;
			n_q    <= '0;
			step_q <= '0;
			sum_q  <= '0;
		end else if (cmd.pick) begin
			if (take_right)
				ru_q <= ru_q + CW'(1);
			else
				lu_q <= lu_q + CW'(1);
			n_q    <= n_q + NW'(1);
			step_q <= step_q + KW'(1);
			sum_q  <= sum_q + SUMW'(pick_val);
			for (int i = 0; i < PK; i++) begin
				if (gt[i])
					buf_q[i] <= (i > 0 && gt[(i > 0) ? i - 1 : 0]) ?
						buf_q[(i > 0) ? i - 1 : 0] : pick_val;
			end
		end

		if (cmd.med_a)
			med_a_q <= buf_q[mid_idx];

		// sign and magnitude; mean: restoring division, one quotient bit a cycle;
		// median: magnitude halved for an even count
		if (cmd.div_start) begin
			neg_q <= dvd[SUMW-1];
			rem_q <= '0;
			dvs_q <= n_q;
			if (avg_kind_q)
				quo_q <= n_q[0] ? mag : (mag >> 1);
			else
				quo_q <= mag;
		end else if (div_cnt_q != '0) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= NW'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[SUMW-2:0], 1'b1};
			end else begin
				rem_q <= trial[NW-1:0];
				quo_q <= {quo_q[SUMW-2:0], 1'b0};
			end
		end

		if (cmd.emit) begin
			out_data.filled_sample <= (n_q == '0) ? '0 : quo_signed[SW-1:0];
			out_data.no_neighbours <= (n_q == '0);
			out_data.last          <= (pos_q + GW'(1) == len_q);
		end
	end

endmodule

@@ src/knn_gap_fill_mean_median.sv @@
// Top level of the k-nearest-neighbor gap filler (mean or median).
//
// Input channel (in_valid/in_ready, in_data): a left or right beat stores one
// context sample as it is accepted, so context beats can follow back to back.
// A fill beat with gap length L (capped at MAX_GAP) produces that many result
// beats on the output channel (out_valid/out_ready), one per gap position, with
// last set on the final one; the context is cleared after the fill. Per
// position the block picks n neighbors (n = k, or fewer when the context runs
// short) one at a time, then for the mean runs a serial restoring divide.
// The median reads the sorted pick buffer and halves only for an even count.
// With no neighbors the result is zero, flagged, and no divide is run.
// in_ready is high only between items: a fill holds it low until its final
// result is loaded into the output register.
// If the receiver stalls, the finished beat waits in the output register and
// the block holds before loading the next one. The next input item can be
// accepted while the final result still waits.
// The user writes configuration (cfg_we, cfg_index, cfg_data) between items;
// the block does not enforce this. Reset clears the context counts, sets mean
// mode and k = 1, and drops any pending result beat.
module knn_gap_fill_mean_median #(
	parameter int MAX_K   = 16,
	parameter int MAX_GAP = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  knngf_pkg::in_item_t             in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output knngf_pkg::out_item_t            out_data,
	input  logic                            cfg_we,
	input  logic [knngf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [knngf_pkg::CFG_W-1:0]     cfg_data
);

	knngf_pkg::cmd_t    cmd;
	knngf_pkg::status_t status;

	knngf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_mode   (in_data.mode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	knngf_dp #(
		.MAX_K   (MAX_K),
		.MAX_GAP (MAX_GAP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the k-nearest-neighbor gap filler: directed table, then random context and fills.
`timescale 1ns / 1ps

module tb;

	localparam int MAXK = 16;
	localparam int MAXG = 64;
	localparam int WATCHDOG = 20000;
	localparam int SW  = knngf_pkg::SAMPLE_W;
	localparam int MW  = knngf_pkg::MODE_W;
	localparam int GW  = knngf_pkg::GAP_W;
	localparam int KW  = knngf_pkg::K_W;
	localparam int CIW = knngf_pkg::CFG_IDX_W;
	localparam int CFW = knngf_pkg::CFG_W;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	knngf_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	knngf_pkg::out_item_t out_data;
	logic cfg_we;
	logic [CIW-1:0] cfg_index;
	logic [CFW-1:0] cfg_data;

	knn_gap_fill_mean_median u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic signed [SW-1:0] left_win[MAXK];
	logic signed [SW-1:0] right_win[MAXK];
	int left_n, right_n;
	logic use_median;
	logic [KW-1:0] k_sel;

	knngf_pkg::out_item_t fill_q[$];
	int errors, beats_in, beats_out, fills_done, idle_cycles;
	bit stall_out;

	typedef struct {
		bit is_cfg;
		logic [CIW-1:0] idx;
		logic [CFW-1:0] val;
		knngf_pkg::in_item_t item;
		bit has_exp;
		logic signed [SW-1:0] exp_sample;
		logic exp_none;
	} row_t;

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("MISMATCH beat %0d %s: got %0d want %0d", beats_out, what, got, want);
	endtask

	function automatic longint middle_of(longint v[], int n);
		longint t;
		int j;
		for (int i = 1; i < n; i++) begin
			t = v[i];
			j = i;
			while (j > 0 && v[j-1] > t) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = t;
		end
		if (n % 2) return v[n/2];
		return (v[n/2-1] + v[n/2]) / 2;
	endfunction

	task automatic predict_beat(input knngf_pkg::in_item_t it);
		int len, n, lu, ru;
		longint sum, res;
		longint picks[];
		knngf_pkg::out_item_t o;
		bit take_r;
		case (it.mode)
			knngf_pkg::MODE_LEFT: begin
				for (int i = MAXK-1; i > 0; i--) left_win[i] = left_win[i-1];
				left_win[0] = it.sample_value;
				if (left_n < MAXK) left_n++;
			end
			knngf_pkg::MODE_RIGHT: begin
				if (right_n < MAXK) begin
					right_win[right_n] = it.sample_value;
					right_n++;
				end
			end
			knngf_pkg::MODE_FILL: begin
				len = (it.gap_length > MAXG) ? MAXG : it.gap_length;
				for (int p = 0; p < len; p++) begin
					picks = new[2*MAXK];
					n = 0; lu = 0; ru = 0; res = 0;
					for (int s = 0; s < k_sel; s++) begin
						if (lu >= left_n && ru >= right_n) break;
						if (lu >= left_n) take_r = 1;
						else if (ru >= right_n) take_r = 0;
						else take_r = (len - p + ru) < (p + 1 + lu);
						if (take_r) picks[n++] = right_win[ru++];
						else picks[n++] = left_win[lu++];
					end
					if (n > 0) begin
						if (!use_median) begin
							sum = 0;
							for (int i = 0; i < n; i++) sum += picks[i];
							res = sum / n;
						end else res = middle_of(picks, n);
					end
					o.filled_sample = res[SW-1:0];
					o.no_neighbours = (n == 0);
					o.last = (p + 1 == len);
					fill_q.push_back(o);
				end
				left_n = 0; right_n = 0;
				for (int i = 0; i < MAXK; i++) begin
					left_win[i] = '0;
					right_win[i] = '0;
				end
				fills_done++;
			end
			default: ;
		endcase
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// output checker and receiver stalls
	always @(posedge clk) begin
		knngf_pkg::out_item_t want;
		if (out_valid && out_ready) begin
			beats_out++;
			if (fill_q.size() == 0) begin
				report("unexpected result beat", 1, 0);
			end else begin
				want = fill_q.pop_front();
				if (out_data.filled_sample !== want.filled_sample)
					report("filled_sample", out_data.filled_sample, want.filled_sample);
				if (out_data.no_neighbours !== want.no_neighbours)
					report("no_neighbours", out_data.no_neighbours, want.no_neighbours);
				if (out_data.last !== want.last)
					report("last", out_data.last, want.last);
			end
		end
		if (arst_n) out_ready <= stall_out ? ($urandom_range(0, 9) < 2) : ($urandom_range(0, 9) < 7);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("Timeout: no beat for %0d cycles", WATCHDOG);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stall_out = 0;
		forever begin
			repeat ($urandom_range(20, 400)) @(posedge clk);
			stall_out = ($urandom_range(0, 3) == 0);
		end
	end

	// valid stays up through a zero gap so the next beat follows directly
	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_beat(input knngf_pkg::in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_beat(it);
		beats_in++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (fill_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIW-1:0] idx, input logic [CFW-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == knngf_pkg::REG_AVERAGE_KIND) use_median = val[0];
		else k_sel = val[KW-1:0];
		@(posedge clk);
	endtask

	function automatic knngf_pkg::in_item_t mk(logic [MW-1:0] m, int v, int l);
		knngf_pkg::in_item_t it;
		it.mode = m;
		it.sample_value = v[SW-1:0];
		it.gap_length = l[GW-1:0];
		return it;
	endfunction

	function automatic row_t beat_row(knngf_pkg::in_item_t it);
		row_t r;
		r.is_cfg = 0;
		r.item = it;
		r.has_exp = 0;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [CIW-1:0] idx, int val);
		row_t r;
		r.is_cfg = 1;
		r.idx = idx;
		r.val = val[CFW-1:0];
		r.has_exp = 0;
		return r;
	endfunction

	initial begin
		row_t dir[$];
		row_t r;
		knngf_pkg::in_item_t it;
		knngf_pkg::out_item_t peek;
		int nctx;
		logic [MW-1:0] m;

		arst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		errors = 0; beats_in = 0; beats_out = 0; fills_done = 0; idle_cycles = 0;
		left_n = 0; right_n = 0; use_median = 0; k_sel = knngf_pkg::K_RESET;
		for (int i = 0; i < MAXK; i++) begin
			left_win[i] = '0;
			right_win[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill with no context right after reset: zero, flagged
		r = beat_row(mk(knngf_pkg::MODE_FILL, 0, 1));
		r.has_exp = 1; r.exp_sample = 0; r.exp_none = 1;
		dir.push_back(r);
		// single left extreme, k = 1: the sample itself
		dir.push_back(beat_row(mk(knngf_pkg::MODE_LEFT, -32768, 0)));
		r = beat_row(mk(knngf_pkg::MODE_FILL, 0, 1));
		r.has_exp = 1; r.exp_sample = -32768; r.exp_none = 0;
		dir.push_back(r);
		dir.push_back(beat_row(mk(knngf_pkg::MODE_RIGHT, 32767, 0)));
		r = beat_row(mk(knngf_pkg::MODE_FILL, 0, 1));
		r.has_exp = 1; r.exp_sample = 32767; r.exp_none = 0;
		dir.push_back(r);
		// tie between left and right goes left; gap length 0 clears context
		dir.push_back(beat_row(mk(knngf_pkg::MODE_LEFT, 100, 0)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_RIGHT, -100, 0)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_FILL, 0, 1)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_LEFT, 5, 0)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_FILL, 0, 0)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_FILL, 0, 2)));
		// spare mode ignored, oversize gap saturates, k above context
		dir.push_back(cfg_row(knngf_pkg::REG_NEIGHBOUR_COUNT, 16));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_SPARE, 1234, 127)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_LEFT, 32767, 0)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_LEFT, 32767, 0)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_RIGHT, 32767, 0)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_FILL, 0, 127)));
		// median, even count, negative truncation
		dir.push_back(cfg_row(knngf_pkg::REG_AVERAGE_KIND, 1));
		dir.push_back(cfg_row(knngf_pkg::REG_NEIGHBOUR_COUNT, 2));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_LEFT, -3, 0)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_RIGHT, 0, 0)));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_FILL, 0, 3)));
		// k zero: no neighbors even with context
		dir.push_back(cfg_row(knngf_pkg::REG_NEIGHBOUR_COUNT, 0));
		dir.push_back(beat_row(mk(knngf_pkg::MODE_LEFT, 7, 0)));
		r = beat_row(mk(knngf_pkg::MODE_FILL, 0, 1));
		r.has_exp = 1; r.exp_sample = 0; r.exp_none = 1;
		dir.push_back(r);

		foreach (dir[i]) begin
			if (dir[i].is_cfg) write_reg(dir[i].idx, dir[i].val);
			else begin
				send_beat(dir[i].item);
				// rows with a typed result are one-sample fills: newest prediction
				if (dir[i].has_exp) begin
					peek = fill_q[$];
					if (peek.filled_sample !== dir[i].exp_sample)
						report("table filled_sample", peek.filled_sample, dir[i].exp_sample);
					if (peek.no_neighbours !== dir[i].exp_none)
						report("table no_neighbours", peek.no_neighbours, dir[i].exp_none);
				end
				idle_gap();
			end
		end

		// random: mostly context runs followed by a fill
		while (beats_in < 210) begin
			if ($urandom_range(0, 7) == 0) begin
				write_reg(knngf_pkg::REG_AVERAGE_KIND, CFW'($urandom_range(0, 1)));
				write_reg(knngf_pkg::REG_NEIGHBOUR_COUNT, CFW'(($urandom_range(0, 5) == 0) ?
					(($urandom_range(0, 1)) ? 16 : 1) : $urandom_range(1, 16)));
			end
			nctx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
			for (int c = 0; c < nctx; c++) begin
				m = ($urandom_range(0, 19) == 0) ? knngf_pkg::MODE_SPARE :
					($urandom_range(0, 1) ? knngf_pkg::MODE_LEFT : knngf_pkg::MODE_RIGHT);
				it = mk(m, $urandom, $urandom);
				send_beat(it);
				idle_gap();
			end
			it = mk(knngf_pkg::MODE_FILL, $urandom,
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8));
			send_beat(it);
			if ($urandom_range(0, 9) == 0) drain();
			idle_gap();
		end

		drain();
		$display("Sent %0d input beats (%0d fills), checked %0d result beats", beats_in,
			fills_done, beats_out);
		$display("Covered mean and median, k from 0 to 16, saturating windows and oversize gaps");
		if (errors == 0 && fill_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ knn_gap_fill_mean_median.f @@
src/knngf_pkg.sv
src/knngf_ctrl.sv
src/knngf_dp.sv
src/knn_gap_fill_mean_median.sv
tb/sv/tb.sv
